@@ src/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 8;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [31:0]      HDR     = 32'(HEADER_BYTES);
    localparam logic [31:0]      ALN_M1  = 32'(ALIGN_BYTES - 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_BAD_FREE = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] CFG_HEAP_BYTES = 2'd1;

    typedef struct packed {
        logic        operation;
        logic [30:0] request_bytes;
        logic [31:0] release_address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] payload_address;
        logic [30:0] granted_bytes;
    } t_rsp;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] payload;
        logic        is_free;
    } t_ent;

endpackage

@@ src/ffha_mem.sv @@
// Block table memory: one write port, one registered read port.
module ffha_mem (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ffha_pkg::IDX_W-1:0] i_wa,
    input  ffha_pkg::t_ent        i_wd,
    input  logic                  i_re,
    input  logic [ffha_pkg::IDX_W-1:0] i_ra,
    output ffha_pkg::t_ent        o_rd
);
    import ffha_pkg::*;

    t_ent r_mem [MAX_BLOCKS];
    t_ent r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;
endmodule

@@ src/first_fit_heap_allocator.sv @@
// First-fit heap allocator: a sequencer walks an address-ordered block table held in one
// synchronous memory, one entry read per cycle. An allocate or free scans from entry 0
// until the first fit or the matching block, then shifts the entries above it up by one
// on a split or down by one or two on a merge, one entry per cycle, and writes the updated
// block entries. Zero-size allocate requests skip the scan and return status ZERO.
// After reset and after every heap_bytes write the table is rebuilt as one free block
// once the sequencer is idle. Exactly one result transaction follows every accepted
// request.
module first_fit_heap_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ffha_pkg::t_req   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ffha_pkg::t_rsp   o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);
    import ffha_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_NEXT = 4'd2;
    localparam logic [3:0] S_SHU  = 4'd3;
    localparam logic [3:0] S_WA   = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_FW   = 4'd6;
    localparam logic [3:0] S_SHD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]       r_state, n_state;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_base;
    logic [30:0]      r_bytes;
    logic             r_op, n_op;
    logic [31:0]      r_rnd, n_rnd;
    logic [32:0]      r_need, n_need;
    logic [31:0]      r_rel, n_rel;
    logic [CNT_W-1:0] r_ra, n_ra;
    logic             r_dv, n_dv;
    logic [IDX_W-1:0] r_di, n_di;
    logic [IDX_W-1:0] r_hi, n_hi;
    t_ent             r_hit, n_hit;
    t_ent             r_prev, n_prev;
    logic             r_split, n_split;
    logic [IDX_W-1:0] r_wi, n_wi;
    logic [1:0]       r_k, n_k;
    t_rsp             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_wa, mem_ra;
    t_ent             mem_wd, rd;

    logic             cfg_wr, accept, issue, hit, pm, nm;
    logic [31:0]      in_rnd, pay_a, pay_b, p0;

    ffha_mem u_mem (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (rd)
    );

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_in_stall  = !(r_state == S_IDLE && !r_pend);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_rnd = ({1'b0, i_in_data.request_bytes} + ALN_M1) & ~ALN_M1;
    assign p0     = ({1'b0, r_bytes} >= HDR) ? {1'b0, r_bytes} - HDR : 32'd0;

    always_comb begin
        n_state = r_state;  n_pend = r_pend;   n_count = r_count;
        n_op = r_op;        n_rnd = r_rnd;     n_need = r_need;   n_rel = r_rel;
        n_ra = r_ra;        n_dv = 1'b0;       n_di = r_di;       n_hi = r_hi;
        n_hit = r_hit;      n_prev = r_prev;   n_split = r_split; n_wi = r_wi;
        n_k = r_k;          n_res = r_res;     n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;
        mem_re = 1'b0;  mem_ra = r_ra[IDX_W-1:0];
        issue = 1'b0;  hit = 1'b0;  pm = 1'b0;  nm = 1'b0;
        pay_a = '0;  pay_b = '0;

        case (r_state)
            S_IDLE: begin
                if (r_pend) begin
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = '{offset: 32'd0, payload: p0, is_free: 1'b1};
                    n_count = CNT_W'(1);
                    n_pend  = 1'b0;
                end else if (accept) begin
                    n_op   = i_in_data.operation;
                    n_rnd  = in_rnd;
                    n_need = {1'b0, in_rnd} + {1'b0, HDR};
                    n_rel  = i_in_data.release_address;
                    n_ra   = '0;
                    n_res  = '0;
                    if (i_in_data.operation == OP_ALLOC && i_in_data.request_bytes == '0) begin
                        n_res.status = ST_ZERO;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                issue = r_ra < r_count;
                if (issue) begin
                    mem_re = 1'b1;
                    n_ra   = r_ra + CNT_W'(1);
                    n_dv   = 1'b1;
                    n_di   = r_ra[IDX_W-1:0];
                end
                if (r_dv) begin
                    if (r_op == OP_ALLOC) begin
                        hit = rd.is_free && ({1'b0, rd.payload} >= r_need);
                    end else begin
                        hit = !rd.is_free && (r_base + rd.offset + HDR == r_rel);
                    end
                end
                if (hit) begin
                    n_hit   = rd;
                    n_hi    = r_di;
                    n_state = S_NEXT;
                end else if (r_dv) begin
                    n_prev = rd;
                end else if (!issue) begin
                    n_res.status = (r_op == OP_ALLOC) ? ST_NOFIT : ST_BAD_FREE;
                    n_state      = S_DONE;
                end
            end
            S_NEXT: begin
                if (r_op == OP_ALLOC) begin
                    if ({1'b0, r_hit.payload} > r_need) begin
                        if (r_count == CNT_MAX) begin
                            n_res.status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_res   = '{status: ST_OK,
                                        payload_address: r_base + r_hit.offset + HDR,
                                        granted_bytes: r_rnd[30:0]};
                            n_split = 1'b1;
                            n_ra    = r_count - CNT_W'(1);
                            n_state = S_SHU;
                        end
                    end else begin
                        n_res   = '{status: ST_OK,
                                    payload_address: r_base + r_hit.offset + HDR,
                                    granted_bytes: r_hit.payload[30:0]};
                        n_split = 1'b0;
                        n_state = S_WA;
                    end
                end else begin
                    pm = (r_hi != '0) && r_prev.is_free;
                    nm = ({1'b0, r_hi} + CNT_W'(1) < r_count) && rd.is_free;
                    pay_a = pm ? r_prev.payload + HDR : 32'd0;
                    pay_b = nm ? rd.payload + HDR : 32'd0;
                    n_res = '{status: ST_OK, payload_address: 32'd0,
                              granted_bytes: r_hit.payload[30:0]};
                    n_hit.offset  = pm ? r_prev.offset : r_hit.offset;
                    n_hit.payload = pay_a + r_hit.payload + pay_b;
                    n_hit.is_free = 1'b1;
                    n_wi = pm ? r_hi - IDX_W'(1) : r_hi;
                    n_k  = {1'b0, pm} + {1'b0, nm};
                    // first surviving entry above the merged run
                    n_ra = {1'b0, r_hi} + CNT_W'(1) + (nm ? CNT_W'(1) : CNT_W'(0));
                    n_state = S_FW;
                end
            end
            S_SHU: begin
                // move entries above the split block up by one, top first
                if (r_dv) begin
                    mem_we = 1'b1;
                    mem_wa = r_di + IDX_W'(1);
                    mem_wd = rd;
                end
                issue = r_ra > {1'b0, r_hi};
                if (issue) begin
                    mem_re = 1'b1;
                    n_ra   = r_ra - CNT_W'(1);
                    n_dv   = 1'b1;
                    n_di   = r_ra[IDX_W-1:0];
                end else if (!r_dv) begin
                    n_state = S_WA;
                end
            end
            S_WA: begin
                mem_we = 1'b1;
                mem_wa = r_hi;
                mem_wd = '{offset: r_hit.offset,
                           payload: r_split ? r_rnd : r_hit.payload, is_free: 1'b0};
                n_state = r_split ? S_WB : S_DONE;
            end
            S_WB: begin
                mem_we  = 1'b1;
                mem_wa  = r_hi + IDX_W'(1);
                mem_wd  = '{offset: r_hit.offset + HDR + r_rnd,
                            payload: r_hit.payload - r_need[31:0], is_free: 1'b1};
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end
            S_FW: begin
                mem_we  = 1'b1;
                mem_wa  = r_wi;
                mem_wd  = r_hit;
                n_state = (r_k == 2'd0) ? S_DONE : S_SHD;
            end
            S_SHD: begin
                // close the gap left by merged entries, bottom first
                if (r_dv) begin
                    mem_we = 1'b1;
                    mem_wa = r_di - IDX_W'(r_k);
                    mem_wd = rd;
                end
                issue = r_ra < r_count;
                if (issue) begin
                    mem_re = 1'b1;
                    n_ra   = r_ra + CNT_W'(1);
                    n_dv   = 1'b1;
                    n_di   = r_ra[IDX_W-1:0];
                end else if (!r_dv) begin
                    n_count = r_count - CNT_W'(r_k);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_wr && i_cfg_index == CFG_HEAP_BYTES) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b1;
            r_count     <= CNT_W'(1);
            r_base      <= 32'd0;
            r_bytes     <= 31'd65536;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
            if (cfg_wr && i_cfg_index == CFG_HEAP_BASE) begin
                r_base <= i_cfg_data;
            end
            if (cfg_wr && i_cfg_index == CFG_HEAP_BYTES) begin
                r_bytes <= i_cfg_data[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_rnd   <= n_rnd;
        r_need  <= n_need;
        r_rel   <= n_rel;
        r_ra    <= n_ra;
        r_di    <= n_di;
        r_hi    <= n_hi;
        r_hit   <= n_hit;
        r_prev  <= n_prev;
        r_split <= n_split;
        r_wi    <= n_wi;
        r_k     <= n_k;
        r_res   <= n_res;
        r_out   <= n_out;
    end
endmodule
